@@ rtl/imconv_pkg.sv @@
package imconv_pkg;

  localparam int COEF_FRAC_BITS = 12;
  localparam int PIX_W          = 24;
  localparam int COEF_W         = COEF_FRAC_BITS + 5;
  localparam int PROD_W         = COEF_W + 9;
  localparam int ACC_W          = PROD_W + 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int LEVEL_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int ROW_W          = 13;
  localparam int IN_ROW_W       = ROW_W + 1;
  localparam int CFG_W          = 13;

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;
  localparam logic [1:0] CFG_FILTER   = 2'd3;

  localparam logic [2:0] FLT_SMOOTH  = 3'd0;
  localparam logic [2:0] FLT_BLUR    = 3'd1;
  localparam logic [2:0] FLT_SHARPEN = 3'd2;
  localparam logic [2:0] FLT_MEAN    = 3'd3;
  localparam logic [2:0] FLT_EMBOSS  = 3'd4;

  localparam int C_ONE     = 1 << COEF_FRAC_BITS;
  localparam int C_NINE    = 9 << COEF_FRAC_BITS;
  localparam int C_NINTH   = ((1 << COEF_FRAC_BITS) + 4) / 9;
  localparam int C_SIXTEEN = ((1 << COEF_FRAC_BITS) + 8) / 16;
  localparam int C_EIGHTH  = ((1 << COEF_FRAC_BITS) + 4) / 8;
  localparam int C_QUARTER = ((1 << COEF_FRAC_BITS) + 2) / 4;
  localparam int C_M23     = -(((2 << COEF_FRAC_BITS) + 1) / 3);
  localparam int C_113     = ((11 << COEF_FRAC_BITS) + 1) / 3;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] taps;
    logic                  last;
  } tap_set_t;

  typedef struct packed {
    logic       gray;
    logic [2:0] filter;
  } filt_cfg_t;

  function automatic logic signed [COEF_W-1:0] coef_of(input logic [2:0] sel,
                                                       input int idx);
    int c;
    c = 0;
    case (sel)
      FLT_SMOOTH:  c = C_NINTH;
      FLT_BLUR:    c = (idx == 4) ? C_QUARTER : ((idx % 2 == 1) ? C_EIGHTH : C_SIXTEEN);
      FLT_SHARPEN: c = (idx == 4) ? C_113 : ((idx % 2 == 1) ? C_M23 : 0);
      FLT_MEAN:    c = (idx == 4) ? C_NINE : -C_ONE;
      FLT_EMBOSS:  c = (idx == 1) ? -C_ONE : ((idx == 7) ? C_ONE : 0);
      default:     c = (idx == 4) ? C_ONE : 0;
    endcase
    return COEF_W'(c);
  endfunction

endpackage

@@ rtl/imconv_ram.sv @@
module imconv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/imconv_front.sv @@
module imconv_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [imconv_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [7:0]                       chan0_in_i,
  input  logic [7:0]                       chan1_in_i,
  input  logic [7:0]                       chan2_in_i,
  input  logic [imconv_pkg::LEVEL_W-1:0]   q_level_i,
  output logic                             push_o,
  output imconv_pkg::tap_set_t             push_data_o,
  output imconv_pkg::filt_cfg_t            filt_cfg_o
);
  import imconv_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [10:0]         width_q;
  logic [ROW_W-1:0]    height_q;
  logic [1:0]          chans_q;
  logic [2:0]          filter_q;
  logic [CW-1:0]       in_col_q, in_col_d, out_col_q, out_col_d;
  logic [IN_ROW_W-1:0] in_row_q, in_row_d;
  logic [ROW_W-1:0]    out_row_q, out_row_d;
  logic [CW-1:0]       wm1;
  logic [ROW_W-1:0]    hm1;
  logic                full, accept, act, emit, last, fwd;

  logic                sb_valid_q, sb_emit_q, sb_last_q, sb_fwd_q;
  logic [PIX_W-1:0]    sb_px_q, sb_fa_q, sb_fb_q;
  logic [CW-1:0]       sb_x_q;
  logic [2:0]          sb_rowv_q, sb_colv_q;
  logic [PIX_W-1:0]    a_rd, b_rd, mid, up;
  logic [PIX_W-1:0]    win_q [3][3];
  logic [PIX_W-1:0]    nwin [3][3];

  always_comb begin
    if (width_q == 11'd0) begin
      wm1 = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(32'(width_q) - 32'd1);
    end
    hm1 = (height_q == '0) ? '0 : height_q - 1'b1;
  end

  assign full       = in_row_q > IN_ROW_W'(hm1);
  assign in_ready_o = (32'(q_level_i) + 32'(sb_valid_q)) < QUEUE_DEPTH;
  assign accept     = in_valid_i && in_ready_o;
  assign act        = accept && (full || !command_i);
  assign emit       = (in_row_q > IN_ROW_W'(1)) || (in_row_q == IN_ROW_W'(1) && in_col_q != '0);
  assign last       = (out_row_q == hm1) && (out_col_q == wm1);
  assign fwd        = sb_valid_q && (sb_x_q == in_col_q);
  assign filt_cfg_o = '{gray: (chans_q <= 2'd1), filter: filter_q};

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (act) begin
      if (emit && last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (in_col_q == wm1) begin
          in_col_d = '0;
          in_row_d = in_row_q + 1'b1;
        end else begin
          in_col_d = in_col_q + 1'b1;
        end
        if (emit) begin
          if (out_col_q == wm1) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd1024;
      height_q  <= ROW_W'(1);
      chans_q   <= 2'd1;
      filter_q  <= FLT_SMOOTH;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIDTH:    width_q  <= cfg_data_i[10:0];
          CFG_HEIGHT:   height_q <= cfg_data_i[ROW_W-1:0];
          CFG_CHANNELS: chans_q  <= cfg_data_i[1:0];
          CFG_FILTER:   filter_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q <= 1'b0;
    end else begin
      sb_valid_q <= act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      sb_px_q   <= full ? '0 : {chan2_in_i, chan1_in_i, chan0_in_i};
      sb_x_q    <= in_col_q;
      sb_emit_q <= emit;
      sb_last_q <= last;
      sb_fwd_q  <= fwd;
      sb_fa_q   <= sb_px_q;
      sb_fb_q   <= mid;
      sb_rowv_q <= {out_row_q != hm1, 1'b1, out_row_q != '0};
      sb_colv_q <= {(out_col_q != wm1) && (in_col_q != '0), 1'b1, out_col_q != '0};
    end
  end

  imconv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_a (
    .clk_i   (clk_i),
    .we_i    (sb_valid_q),
    .waddr_i (sb_x_q),
    .wdata_i (sb_px_q),
    .raddr_i (in_col_q),
    .rdata_o (a_rd)
  );

  imconv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_b (
    .clk_i   (clk_i),
    .we_i    (sb_valid_q),
    .waddr_i (sb_x_q),
    .wdata_i (mid),
    .raddr_i (in_col_q),
    .rdata_o (b_rd)
  );

  assign mid = sb_fwd_q ? sb_fa_q : a_rd;
  assign up  = sb_fwd_q ? sb_fb_q : b_rd;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nwin[r][0] = win_q[r][1];
      nwin[r][1] = win_q[r][2];
    end
    nwin[0][2] = up;
    nwin[1][2] = mid;
    nwin[2][2] = sb_px_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_data_o.taps[r*3+c] = (sb_rowv_q[r] && sb_colv_q[c]) ? nwin[r][c] : '0;
      end
    end
    push_data_o.last = sb_last_q;
  end

  assign push_o = sb_valid_q && sb_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (sb_valid_q) begin
      win_q <= nwin;
    end
  end
endmodule

@@ rtl/imconv_back.sv @@
module imconv_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  imconv_pkg::tap_set_t           push_data_i,
  output logic [imconv_pkg::LEVEL_W-1:0] q_level_o,
  input  imconv_pkg::filt_cfg_t          filt_cfg_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     chan0_out_o,
  output logic [7:0]                     chan1_out_o,
  output logic [7:0]                     chan2_out_o,
  output logic                           frame_last_o
);
  import imconv_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  tap_set_t                 q_mem_q [QUEUE_DEPTH];
  logic [PW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [LEVEL_W-1:0]       level_q;
  logic                     pop, p_ready, s_ready;
  logic                     p_valid_q, p_last_q;
  logic signed [PROD_W-1:0] prod_q [3][9];
  logic signed [PROD_W-1:0] prod_d [3][9];
  logic [7:0]               res [3];

  assign q_level_o = level_q;
  assign s_ready   = !out_valid_o || out_ready_i;
  assign p_ready   = !p_valid_q || s_ready;
  assign pop       = (level_q != '0) && p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      level_q <= level_q + LEVEL_W'(push_i) - LEVEL_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 9; i++) begin
        prod_d[k][i] = coef_of(filt_cfg_i.filter, i)
                     * $signed({1'b0, q_mem_q[rd_ptr_q].taps[i][8*k +: 8]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (p_ready) begin
      p_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      prod_q   <= prod_d;
      p_last_q <= q_mem_q[rd_ptr_q].last;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shr;
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int i = 0; i < 9; i++) begin
        acc = acc + ACC_W'(prod_q[k][i]);
      end
      shr = acc >>> COEF_FRAC_BITS;
      if (acc <= 0) begin
        res[k] = 8'd0;
      end else if (shr > ACC_W'(255)) begin
        res[k] = 8'd255;
      end else begin
        res[k] = shr[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s_ready) begin
      out_valid_o <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready && p_valid_q) begin
      chan0_out_o  <= res[0];
      chan1_out_o  <= filt_cfg_i.gray ? 8'd0 : res[1];
      chan2_out_o  <= filt_cfg_i.gray ? 8'd0 : res[2];
      frame_last_o <= p_last_q;
    end
  end
endmodule

@@ rtl/image_conv3x3_filter.sv @@
// Channel   Direction  Handshake                Payload
// cfg       in         cfg_we_i                 cfg_index_i, cfg_data_i
// pixel in  in         in_valid_i / in_ready_o  command_i, chan0..2_in_i
// pixel out out        out_valid_o / out_ready_i chan0..2_out_o, frame_last_o
// One request per clock while in_ready_o is high; the output port is registered.
// The rate is set by each line store's single read and write per request.
// Results lag the stream by one row plus one pixel; drains release the tail.
// Reset clears counters and control; no clearing pass over the line stores.
// Four-entry queue; in_ready_o drops when queued plus sideband items reach four.
module image_conv3x3_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [imconv_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [7:0]                   chan0_in_i,
  input  logic [7:0]                   chan1_in_i,
  input  logic [7:0]                   chan2_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   chan0_out_o,
  output logic [7:0]                   chan1_out_o,
  output logic [7:0]                   chan2_out_o,
  output logic                         frame_last_o
);
  import imconv_pkg::*;

  logic               push;
  tap_set_t           push_data;
  logic [LEVEL_W-1:0] q_level;
  filt_cfg_t          filt_cfg;

  imconv_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .chan0_in_i  (chan0_in_i),
    .chan1_in_i  (chan1_in_i),
    .chan2_in_i  (chan2_in_i),
    .q_level_i   (q_level),
    .push_o      (push),
    .push_data_o (push_data),
    .filt_cfg_o  (filt_cfg)
  );

  imconv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .q_level_o    (q_level),
    .filt_cfg_i   (filt_cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .chan0_out_o  (chan0_out_o),
    .chan1_out_o  (chan1_out_o),
    .chan2_out_o  (chan2_out_o),
    .frame_last_o (frame_last_o)
  );
endmodule

@@ rtl/imconv_checker.sv @@
module imconv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] chan0_out_o,
  input logic [7:0] chan1_out_o,
  input logic [7:0] chan2_out_o,
  input logic       frame_last_o
);
  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_ready_o)
    else $error("input not ready right after reset");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(rst_ni, 1) || !$past(rst_ni, 2) || !$past(rst_ni, 3)) |-> !out_valid_o)
    else $error("result appeared within three cycles of reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(chan0_out_o) && $stable(chan1_out_o)
      && $stable(chan2_out_o) && $stable(frame_last_o))
    else $error("output payload changed while stalled");
endmodule

bind image_conv3x3_filter imconv_checker u_imconv_checker (.*);
